/* sv/sre_pkg.sv */
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types and constants for the shift-register output expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sre_pkg;

  localparam int unsigned CmdW          = 3;
  localparam int unsigned IdxW          = 5;
  localparam int unsigned PosW          = 5;
  localparam int unsigned ChipBits      = 8;
  localparam int unsigned DefChipCount  = 3;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_SET_LINE    = 3'd0,
    CMD_CLEAR_LINE  = 3'd1,
    CMD_TOGGLE_LINE = 3'd2,
    CMD_SET_ALL     = 3'd3,
    CMD_CLEAR_ALL   = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [IdxW-1:0] index;
  } entry_t;

endpackage

`default_nettype wire

/* sv/sre_front.sv */
// ----------------------------------------------------------------------------
// sre_front
// Accepts command words, drops unknown codes and out-of-range lines, and
// pushes the rest into the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sre_front #(
  parameter int unsigned LineCount = sre_pkg::DefChipCount * sre_pkg::ChipBits
) (
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [sre_pkg::CmdW-1:0]    command_i,
  input  wire logic [sre_pkg::IdxW-1:0]    io_index_i,
  input  wire logic                        full_i,
  output      logic                        push_o,
  output      sre_pkg::entry_t             entry_o
);

  logic keep;
  logic in_range;

  assign in_range = 32'(io_index_i) < LineCount;

  always_comb begin
    case (sre_pkg::cmd_e'(command_i))
      sre_pkg::CMD_SET_LINE,
      sre_pkg::CMD_CLEAR_LINE,
      sre_pkg::CMD_TOGGLE_LINE: keep = in_range;
      sre_pkg::CMD_SET_ALL,
      sre_pkg::CMD_CLEAR_ALL:   keep = 1'b1;
      default:                  keep = 1'b0;
    endcase
  end

  assign in_stall_o    = full_i;
  assign push_o        = in_valid_i && !full_i && keep;
  assign entry_o.cmd   = sre_pkg::cmd_e'(command_i);
  assign entry_o.index = io_index_i;

endmodule

`default_nettype wire

/* sv/sre_queue.sv */
// ----------------------------------------------------------------------------
// sre_queue
// Short command queue between the front and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sre_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sre_pkg::entry_t  entry_i,
  output      logic             full_o,
  output      logic             empty_o,
  input  wire logic             pop_i,
  output      sre_pkg::entry_t  entry_o
);

  localparam int unsigned PtrW = $clog2(sre_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(sre_pkg::QueueDepth + 1);

  sre_pkg::entry_t       mem_q [sre_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = count_q == CntW'(sre_pkg::QueueDepth);
  assign empty_o = count_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* sv/sre_back.sv */
// ----------------------------------------------------------------------------
// sre_back
// Holds the output image, applies one queued command and shifts the whole
// image out, farthest chip first, MSB first, one word per line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sre_back #(
  parameter int unsigned LineCount = sre_pkg::DefChipCount * sre_pkg::ChipBits
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     empty_i,
  input  wire sre_pkg::entry_t          entry_i,
  output      logic                     pop_o,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic                     serial_bit_o,
  output      logic [sre_pkg::PosW-1:0] bit_position_o,
  output      logic                     latch_after_o
);

  localparam int unsigned LineW = $clog2(LineCount);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_e;

  state_e               state_q, state_d;
  logic [LineCount-1:0] image_q, image_d;
  logic [LineW-1:0]     pos_q, pos_d;
  logic [LineCount-1:0] mask;

  assign mask = {{(LineCount-1){1'b0}}, 1'b1} << entry_i.index;
  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    image_d = image_q;
    pos_d   = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          case (entry_i.cmd)
            sre_pkg::CMD_SET_LINE:    image_d = image_q | mask;
            sre_pkg::CMD_CLEAR_LINE:  image_d = image_q & ~mask;
            sre_pkg::CMD_TOGGLE_LINE: image_d = image_q ^ mask;
            sre_pkg::CMD_SET_ALL:     image_d = '1;
            sre_pkg::CMD_CLEAR_ALL:   image_d = '0;
            default:                  image_d = image_q;
          endcase
          pos_d   = LineW'(LineCount - 1);
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!out_stall_i) begin
          if (pos_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      image_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      image_q <= image_d;
      pos_q   <= pos_d;
    end
  end

  assign out_valid_o    = state_q == ST_SEND;
  assign serial_bit_o   = image_q[pos_q];
  assign bit_position_o = sre_pkg::PosW'(pos_q);
  assign latch_after_o  = pos_q == '0;

endmodule

`default_nettype wire

/* sv/shift_register_output_expander.sv */
// ----------------------------------------------------------------------------
// shift_register_output_expander
// Keeps a shadow image of CHIP_COUNT chained 8-bit shift-register chips and
// resends the whole image after every valid command.
//
// Input channel: in_valid_i / in_stall_o with command_i and io_index_i.
// Commands: set, clear or toggle one line, set all, clear all. Unknown codes
// and single-line commands beyond the line count are dropped without output.
// Output channel: out_valid_o / out_stall_i, one word per serial bit with
// serial_bit_o, bit_position_o and latch_after_o (high on line 0, the last).
// Each command yields CHIP_COUNT*8 words, farthest chip first, MSB first.
// An accepted command passes through the queue, then the serializer applies it in
// its idle state and shifts one word per cycle while out_stall_i is low; the
// single serializer takes a new command only after the last word of a frame.
// A two-entry queue lets new commands in while a frame is being shifted.
// Reset clears the image and the queue; no frame is sent at reset.
// A stalled receiver holds the current word and pauses the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shift_register_output_expander #(
  parameter int unsigned CHIP_COUNT = sre_pkg::DefChipCount
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire logic [sre_pkg::CmdW-1:0] command_i,
  input  wire logic [sre_pkg::IdxW-1:0] io_index_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic                     serial_bit_o,
  output      logic [sre_pkg::PosW-1:0] bit_position_o,
  output      logic                     latch_after_o
);

  localparam int unsigned LineCount = CHIP_COUNT * sre_pkg::ChipBits;

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  sre_pkg::entry_t push_entry;
  sre_pkg::entry_t head_entry;

  sre_front #(
    .LineCount (LineCount)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .io_index_i (io_index_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  sre_back #(
    .LineCount (LineCount)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .serial_bit_o   (serial_bit_o),
    .bit_position_o (bit_position_o),
    .latch_after_o  (latch_after_o)
  );

endmodule

`default_nettype wire
